// File: hdl/serial_bootloader_command_parser_assert.svh
// Assertion macros of the command parser top level.
`ifndef SERIAL_BOOTLOADER_COMMAND_PARSER_ASSERT_SVH
`define SERIAL_BOOTLOADER_COMMAND_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SBCP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("sbcp assertion failed");
`define SBCP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sbcp assertion failed");
`else
`define SBCP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SBCP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hdl/sbcp_pkg.sv
// Shared constants and control/status types of the command parser.
`timescale 1ns / 1ps
package sbcp_pkg;

  localparam int SBCP_PAGE_BYTES = 128;
  localparam int SBCP_PADDR_W    = 2;

  localparam logic [SBCP_PADDR_W-1:0] REG_ADDR_CELL = 2'd0;

  // protocol bytes
  localparam logic [7:0] SYNC_BYTE    = 8'hAA;
  localparam logic [7:0] CMD_NOP      = 8'h4E;
  localparam logic [7:0] CMD_SETADDR  = 8'h41;
  localparam logic [7:0] CMD_SHOW     = 8'h44;
  localparam logic [7:0] CMD_EEWRITE  = 8'h45;
  localparam logic [7:0] CMD_EEREAD   = 8'h47;
  localparam logic [7:0] CMD_SET_MASK = 8'h4D;
  localparam logic [7:0] CMD_PROGRAM  = 8'h50;
  localparam logic [7:0] CMD_RUN_APP  = 8'h52;
  localparam logic [7:0] CMD_FINISH   = 8'h46;

  // result kinds
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_BOOT   = 3'd1;
  localparam logic [2:0] KIND_FINISH = 3'd2;
  localparam logic [2:0] KIND_LED    = 3'd3;
  localparam logic [2:0] KIND_EEWR   = 3'd4;
  localparam logic [2:0] KIND_EERD   = 3'd5;
  localparam logic [2:0] KIND_FLASH  = 3'd6;
  localparam logic [2:0] KIND_FAULT  = 3'd7;

  typedef struct packed {
    logic       res_load;
    logic [2:0] res_kind;
    logic       led_from_byte;
    logic       set_mask;
    logic       etgt_cfg;
    logic       etgt_byte;
    logic       edata;
    logic       page_hi;
    logic       page_lo;
    logic       page_data;
    logic       emit_start;
    logic       emit_ok;
    logic       emit_bad;
  } sbcp_cmd_t;

  typedef struct packed {
    logic selected;
    logic page_full;
    logic sum_ok;
    logic res_free;
    logic emit_fire;
    logic emit_last;
  } sbcp_stat_t;

endpackage

// File: hdl/sbcp_in_if.sv
// Input byte channel of the command parser.
`timescale 1ns / 1ps
interface sbcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: hdl/sbcp_out_if.sv
// Result channel of the command parser.
`timescale 1ns / 1ps
interface sbcp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] target;
  logic [15:0] payload;
  logic        last;

  modport source (output valid, output kind, output target, output payload, output last,
                  input ready);
  modport sink (input valid, input kind, input target, input payload, input last,
                output ready);
endinterface

// File: hdl/sbcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sbcp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/sbcp_ctrl.sv
// Packet parser state machine: decodes bytes and sequences the page readout.
`timescale 1ns / 1ps
module sbcp_ctrl import sbcp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sbcp_in_if.sink    in_ch,
  input  sbcp_stat_t stat,
  output sbcp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SYNC     = 4'd1;
  localparam logic [3:0] S_MASK     = 4'd2;
  localparam logic [3:0] S_EADDR    = 4'd3;
  localparam logic [3:0] S_EDATA    = 4'd4;
  localparam logic [3:0] S_GADDR    = 4'd5;
  localparam logic [3:0] S_AHI      = 4'd6;
  localparam logic [3:0] S_ALO      = 4'd7;
  localparam logic [3:0] S_DATA     = 4'd8;
  localparam logic [3:0] S_SUM      = 4'd9;
  localparam logic [3:0] S_PRIME    = 4'd10;
  localparam logic [3:0] S_EMIT_OK  = 4'd11;
  localparam logic [3:0] S_EMIT_BAD = 4'd12;
  localparam logic [3:0] S_HALT     = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       in_ready;
  logic       acc;
  logic [7:0] b;

  assign b        = in_ch.rx_byte;
  assign in_ready = !(state_r inside {S_PRIME, S_EMIT_OK, S_EMIT_BAD}) && stat.res_free;
  assign acc      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit_ok  = (state_r == S_EMIT_OK);
    cmd.emit_bad = (state_r == S_EMIT_BAD);
    case (state_r)
      S_SYNC: begin
        if (acc) begin
          state_nxt = S_IDLE;
          if (b == CMD_NOP) begin
            state_nxt = S_IDLE;
          end else if (b == SYNC_BYTE) begin
            state_nxt = S_SYNC;
          end else if (b == CMD_SET_MASK) begin
            state_nxt = S_MASK;
          end else if (stat.selected) begin
            case (b)
              CMD_RUN_APP: begin
                cmd.res_load = 1'b1;
                cmd.res_kind = KIND_BOOT;
              end
              CMD_SHOW: begin
                cmd.res_load = 1'b1;
                cmd.res_kind = KIND_LED;
              end
              CMD_SETADDR: begin
                cmd.etgt_cfg = 1'b1;
                state_nxt    = S_EDATA;
              end
              CMD_EEWRITE: state_nxt = S_EADDR;
              CMD_EEREAD:  state_nxt = S_GADDR;
              CMD_PROGRAM: state_nxt = S_AHI;
              CMD_FINISH: begin
                cmd.res_load = 1'b1;
                cmd.res_kind = KIND_FINISH;
              end
              default: state_nxt = S_IDLE;
            endcase
          end
        end
      end
      S_MASK: begin
        if (acc) begin
          cmd.set_mask = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_EADDR: begin
        if (acc) begin
          cmd.etgt_byte = 1'b1;
          state_nxt     = S_EDATA;
        end
      end
      S_EDATA: begin
        if (acc) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = KIND_EEWR;
          cmd.edata    = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_GADDR: begin
        if (acc) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = KIND_EERD;
          state_nxt    = S_IDLE;
        end
      end
      S_AHI: begin
        if (acc) begin
          cmd.res_load      = 1'b1;
          cmd.res_kind      = KIND_LED;
          cmd.led_from_byte = 1'b1;
          cmd.page_hi       = 1'b1;
          state_nxt         = S_ALO;
        end
      end
      S_ALO: begin
        if (acc) begin
          cmd.page_lo = 1'b1;
          state_nxt   = S_DATA;
        end
      end
      S_DATA: begin
        if (acc) begin
          cmd.page_data = 1'b1;
          if (stat.page_full) begin
            state_nxt = S_SUM;
          end
        end
      end
      S_SUM: begin
        if (acc) begin
          cmd.emit_start = 1'b1;
          state_nxt      = stat.sum_ok ? S_PRIME : S_EMIT_BAD;
        end
      end
      // lets the page RAM register word 0 before the readout starts
      S_PRIME: state_nxt = S_EMIT_OK;
      S_EMIT_OK: begin
        if (stat.emit_fire && stat.emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT_BAD: begin
        if (stat.emit_fire && stat.emit_last) begin
          state_nxt = S_HALT;
        end
      end
      S_HALT: state_nxt = S_HALT;
      default: begin
        if (acc) begin
          state_nxt = (b == SYNC_BYTE) ? S_SYNC : S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/sbcp_datapath.sv
// Address/mask registers, page buffer, checksum and result registers.
`timescale 1ns / 1ps
module sbcp_datapath import sbcp_pkg::*; #(
  parameter int PAGE_BYTES = SBCP_PAGE_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output logic [7:0]  cell_loc,
  input  sbcp_cmd_t   cmd,
  output sbcp_stat_t  stat,
  sbcp_out_if.source  out_ch
);

  localparam int FW    = $clog2(PAGE_BYTES);
  localparam int WORDS = (PAGE_BYTES + 1) / 2;
  localparam int WAW   = $clog2(WORDS);
  localparam logic [FW-1:0]  FILL_LAST = FW'(PAGE_BYTES - 1);
  localparam logic [WAW-1:0] WORD_LAST = WAW'(WORDS - 1);

  logic [7:0]     cell_r;
  logic [7:0]     dev_r;
  logic [7:0]     mask_r;
  logic [7:0]     etgt_r;
  logic [15:0]    base_r;
  logic [FW-1:0]  fill_r;
  logic [7:0]     sum_r;
  logic [7:0]     even_r;
  logic [WAW-1:0] wp_r;

  logic           res_valid_r;
  logic [2:0]     res_kind_r;
  logic [15:0]    res_target_r;
  logic [15:0]    res_payload_r;
  logic [15:0]    res_target_nxt;
  logic [15:0]    res_payload_nxt;

  logic           ram_we;
  logic [WAW-1:0] ram_waddr;
  logic [15:0]    ram_wdata;
  logic [WAW-1:0] ram_raddr;
  logic [15:0]    ram_rdata;

  logic           emitting;
  logic [15:0]    word_off;

  assign cell_loc = cell_r;
  assign emitting = cmd.emit_ok || cmd.emit_bad;
  assign word_off = 16'({wp_r, 1'b0});

  assign stat.selected  = (dev_r == 8'hFF) || (mask_r == 8'hFF) || (dev_r == mask_r) ||
                          ((mask_r[7:4] == 4'hF) && (dev_r[7:4] == mask_r[3:0]));
  assign stat.page_full = (fill_r == FILL_LAST);
  assign stat.sum_ok    = (~sum_r == rx_byte);
  assign stat.res_free  = !res_valid_r || out_ch.ready;
  assign stat.emit_fire = emitting && out_ch.ready;
  assign stat.emit_last = (wp_r == WORD_LAST);

  always_comb begin
    res_target_nxt  = 16'h0000;
    res_payload_nxt = 16'h0000;
    case (cmd.res_kind)
      KIND_LED:  res_payload_nxt = {8'h00, cmd.led_from_byte ? rx_byte : dev_r};
      KIND_EEWR: begin
        res_target_nxt  = {8'h00, etgt_r};
        res_payload_nxt = {8'h00, rx_byte};
      end
      KIND_EERD: res_target_nxt = {8'h00, rx_byte};
      default: begin
        res_target_nxt  = 16'h0000;
        res_payload_nxt = 16'h0000;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r      <= 8'h00;
      dev_r       <= 8'hFF;
      mask_r      <= 8'hFF;
      etgt_r      <= 8'h00;
      base_r      <= 16'h0000;
      fill_r      <= '0;
      sum_r       <= 8'h00;
      wp_r        <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cell_r <= cfg_wdata;
      end
      if (cmd.set_mask) begin
        mask_r <= rx_byte;
      end
      if (cmd.etgt_cfg) begin
        etgt_r <= cell_r;
      end
      if (cmd.etgt_byte) begin
        etgt_r <= rx_byte;
      end
      if (cmd.edata && (etgt_r == cell_r)) begin
        dev_r <= rx_byte;
      end
      if (cmd.page_hi) begin
        base_r <= {rx_byte, 8'h00};
        fill_r <= '0;
        sum_r  <= 8'h00;
      end
      if (cmd.page_lo) begin
        base_r[7:0] <= rx_byte;
      end
      if (cmd.page_data) begin
        sum_r  <= sum_r + rx_byte;
        fill_r <= fill_r + 1'b1;
      end
      if (cmd.emit_start) begin
        wp_r <= '0;
      end else if (stat.emit_fire && !stat.emit_last) begin
        wp_r <= wp_r + 1'b1;
      end
      if (cmd.res_load) begin
        res_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.page_data && !fill_r[0]) begin
      even_r <= rx_byte;
    end
    if (cmd.res_load) begin
      res_kind_r    <= cmd.res_kind;
      res_target_r  <= res_target_nxt;
      res_payload_r <= res_payload_nxt;
    end
  end

  // bytes pair up into little-endian words; an odd final byte gets a zero high byte
  assign ram_we    = cmd.page_data && (fill_r[0] || stat.page_full);
  assign ram_waddr = WAW'(fill_r >> 1);
  assign ram_wdata = fill_r[0] ? {rx_byte, even_r} : {8'h00, rx_byte};

  // hold the address while stalled so the read data stays put
  always_comb begin
    if (cmd.emit_ok) begin
      ram_raddr = (out_ch.ready && !stat.emit_last) ? wp_r + 1'b1 : wp_r;
    end else begin
      ram_raddr = '0;
    end
  end

  sbcp_ram #(
    .WIDTH (16),
    .DEPTH (WORDS)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_ch.valid   = res_valid_r || emitting;
  assign out_ch.kind    = cmd.emit_ok ? KIND_FLASH : (cmd.emit_bad ? KIND_FAULT : res_kind_r);
  assign out_ch.target  = cmd.emit_ok ? base_r + word_off :
                          (cmd.emit_bad ? word_off : res_target_r);
  assign out_ch.payload = cmd.emit_ok ? ram_rdata : (cmd.emit_bad ? 16'hFFFF : res_payload_r);
  assign out_ch.last    = emitting ? stat.emit_last : 1'b1;

endmodule

// File: hdl/serial_bootloader_command_parser.sv
// Top level of the serial bootloader command parser.
//
//  port        dir   handshake                   content
//  in_ch       in    valid/ready                 rx_byte
//  out_ch      out   valid/ready                 kind, target, payload, last
//  APB (p*)    in    psel+penable, pready = 1    address_cell_location at 0x0
//
// A byte is taken once the single-result register is free or being drained, except during a readout.
// A good page sum starts a readout of (PAGE_BYTES+1)/2 words: a priming state for the page RAM
// read, then one word per cycle, stalled only by out_ch.ready.
// Fault words follow the bad sum directly at one per cycle, also stalled by out_ch.ready; the block then ignores
// every byte until reset. Reset is synchronous; the page RAM is not cleared.
`timescale 1ns / 1ps
`include "serial_bootloader_command_parser_assert.svh"
module serial_bootloader_command_parser import sbcp_pkg::*; #(
  parameter int PAGE_BYTES = SBCP_PAGE_BYTES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  sbcp_in_if.sink                 in_ch,
  sbcp_out_if.source              out_ch,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [SBCP_PADDR_W-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  sbcp_cmd_t  cmd;
  sbcp_stat_t stat;
  logic       cfg_we;
  logic [7:0] cell_loc;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == REG_ADDR_CELL);
  assign prdata = (paddr == REG_ADDR_CELL) ? {24'h000000, cell_loc} : 32'h00000000;

  sbcp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .stat  (stat),
    .cmd   (cmd)
  );

  sbcp_datapath #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_byte   (in_ch.rx_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (pwdata[7:0]),
    .cell_loc  (cell_loc),
    .cmd       (cmd),
    .stat      (stat),
    .out_ch    (out_ch)
  );

  // no byte request is taken while page words go out
  `SBCP_ASSERT_IMP(a_no_accept_in_emit, clk, rst_n,
                   in_ch.valid && in_ch.ready, !(cmd.emit_ok || cmd.emit_bad))
  // a pending single result is never overwritten
  `SBCP_ASSERT_IMP(a_no_result_overrun, clk, rst_n, cmd.res_load, stat.res_free)
  // the final word of a readout ends the readout
  `SBCP_ASSERT_NXT(a_emit_ends, clk, rst_n,
                   stat.emit_fire && stat.emit_last, !(cmd.emit_ok || cmd.emit_bad))

endmodule

// File: sim/tb_top.sv
// Self-checking bench for the bootloader command parser: directed and random byte streams.
`timescale 1ns / 1ps
module tb_top;
  import sbcp_pkg::*;

  localparam int PAGE_BYTES = SBCP_PAGE_BYTES;
  // no register lives here; writes to it must be dropped
  localparam logic [SBCP_PADDR_W-1:0] REG_ADDR_SPARE = 2'd1;

  typedef enum logic [3:0] {
    RXP_IDLE, RXP_SYNCED, RXP_MASK_ARG, RXP_EE_ADDR, RXP_EE_DATA,
    RXP_RD_ADDR, RXP_PAGE_HI, RXP_PAGE_LO, RXP_PAGE_FILL, RXP_PAGE_SUM
  } rx_phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] target;
    logic [15:0] payload;
    logic        last;
  } boot_req_t;

  logic                    clk;
  logic                    rst_n;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [SBCP_PADDR_W-1:0] paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;

  sbcp_in_if  in_ch();
  sbcp_out_if out_ch();

  serial_bootloader_command_parser dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // expected parser state
  rx_phase_t   phase_m    = RXP_IDLE;
  logic [7:0]  dev_addr_m = 8'hFF;
  logic [7:0]  mask_m     = 8'hFF;
  logic [7:0]  ee_tgt_m   = 8'h00;
  logic [15:0] base_m     = 16'h0000;
  logic [7:0]  fill_m     = 8'h00;
  logic [7:0]  sum_m      = 8'h00;
  logic [7:0]  cell_loc_m = 8'h00;
  logic        halted_m   = 1'b0;
  logic [7:0]  page_m [PAGE_BYTES];

  boot_req_t   due_requests[$];
  logic [7:0]  rx_backlog[$];
  int          n_queued   = 0;
  int          n_taken    = 0;
  int          err_count  = 0;
  logic        rx_took    = 1'b0;
  int          in_gap_pct = 30;
  int          out_stall_pct = 30;

  // stimulus-side guesses at the node's address, used only to bias masks and write targets
  logic [7:0]  gen_cell = 8'h00;
  logic [7:0]  gen_addr = 8'hFF;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic node_selected();
    return dev_addr_m == 8'hFF || mask_m == 8'hFF || dev_addr_m == mask_m ||
           (mask_m >= 8'hF0 && dev_addr_m[7:4] == mask_m[3:0]);
  endfunction

  function automatic logic [7:0] page_byte(int idx);
    return (idx >= PAGE_BYTES) ? 8'h00 : page_m[7'(idx)];
  endfunction

  function automatic void add_due(logic [2:0] kind, logic [15:0] target,
                                  logic [15:0] payload, logic last);
    boot_req_t r;
    r.kind    = kind;
    r.target  = target;
    r.payload = payload;
    r.last    = last;
    due_requests.push_back(r);
  endfunction

  function automatic void parse_rx_byte(logic [7:0] b);
    int i;
    if (halted_m) return;
    case (phase_m)
      RXP_SYNCED: begin
        phase_m = RXP_IDLE;
        if (b == SYNC_BYTE) begin
          phase_m = RXP_SYNCED;
        end else if (b == CMD_SET_MASK) begin
          phase_m = RXP_MASK_ARG;
        end else if (b != CMD_NOP && node_selected()) begin
          case (b)
            CMD_RUN_APP: add_due(KIND_BOOT, 16'h0, 16'h0, 1'b1);
            CMD_SHOW:    add_due(KIND_LED, 16'h0, {8'h00, dev_addr_m}, 1'b1);
            CMD_SETADDR: begin
              ee_tgt_m = cell_loc_m;
              phase_m  = RXP_EE_DATA;
            end
            CMD_EEWRITE: phase_m = RXP_EE_ADDR;
            CMD_EEREAD:  phase_m = RXP_RD_ADDR;
            CMD_PROGRAM: phase_m = RXP_PAGE_HI;
            CMD_FINISH:  add_due(KIND_FINISH, 16'h0, 16'h0, 1'b1);
            default: ;
          endcase
        end
      end
      RXP_MASK_ARG: begin
        mask_m  = b;
        phase_m = RXP_IDLE;
      end
      RXP_EE_ADDR: begin
        ee_tgt_m = b;
        phase_m  = RXP_EE_DATA;
      end
      RXP_EE_DATA: begin
        add_due(KIND_EEWR, {8'h00, ee_tgt_m}, {8'h00, b}, 1'b1);
        if (ee_tgt_m == cell_loc_m) dev_addr_m = b;
        phase_m = RXP_IDLE;
      end
      RXP_RD_ADDR: begin
        add_due(KIND_EERD, {8'h00, b}, 16'h0, 1'b1);
        phase_m = RXP_IDLE;
      end
      RXP_PAGE_HI: begin
        add_due(KIND_LED, 16'h0, {8'h00, b}, 1'b1);
        base_m  = {b, 8'h00};
        fill_m  = 8'h00;
        sum_m   = 8'h00;
        phase_m = RXP_PAGE_LO;
      end
      RXP_PAGE_LO: begin
        base_m  = base_m | {8'h00, b};
        phase_m = RXP_PAGE_FILL;
      end
      RXP_PAGE_FILL: begin
        page_m[fill_m[6:0]] = b;
        sum_m  = sum_m + b;
        fill_m = fill_m + 8'd1;
        phase_m = (int'(fill_m) >= PAGE_BYTES) ? RXP_PAGE_SUM : RXP_PAGE_FILL;
      end
      RXP_PAGE_SUM: begin
        phase_m = RXP_IDLE;
        if (~sum_m == b) begin
          for (i = 0; i < PAGE_BYTES; i += 2)
            add_due(KIND_FLASH, base_m + 16'(i), {page_byte(i + 1), page_byte(i)},
                    i + 2 >= PAGE_BYTES);
        end else begin
          for (i = 0; i < PAGE_BYTES; i += 2)
            add_due(KIND_FAULT, 16'(i), 16'hFFFF, i + 2 >= PAGE_BYTES);
          halted_m = 1'b1;
        end
      end
      default: phase_m = (b == SYNC_BYTE) ? RXP_SYNCED : RXP_IDLE;
    endcase
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endfunction

  // sample side: config writes, accepted bytes, returned requests
  always @(posedge clk) begin
    boot_req_t want;
    rx_took = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && psel && penable && pwrite && pready && paddr == REG_ADDR_CELL)
      cell_loc_m = pwdata[7:0];
    if (rx_took) begin
      n_taken++;
      parse_rx_byte(in_ch.rx_byte);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_requests.size() == 0) begin
        $error("request with none due: kind %0d target %0h payload %0h last %0b",
               out_ch.kind, out_ch.target, out_ch.payload, out_ch.last);
        err_count++;
      end else begin
        want = due_requests.pop_front();
        check_field("kind", 16'(want.kind), 16'(out_ch.kind));
        check_field("target", want.target, out_ch.target);
        check_field("payload", want.payload, out_ch.payload);
        check_field("last", 16'(want.last), 16'(out_ch.last));
      end
    end
  end

  // byte driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || rx_took) begin
      if (rx_backlog.size() != 0 && $urandom_range(0, 99) >= in_gap_pct) begin
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= rx_backlog.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  function automatic void queue_rx(logic [7:0] b);
    rx_backlog.push_back(b);
    n_queued++;
  endfunction

  function automatic void queue_cmd(logic [7:0] cmd);
    queue_rx(SYNC_BYTE);
    queue_rx(cmd);
  endfunction

  function automatic void queue_page(logic [7:0] hi, logic [7:0] lo, logic good);
    logic [7:0] s;
    logic [7:0] d;
    int i;
    s = 8'h00;
    queue_cmd(CMD_PROGRAM);
    queue_rx(hi);
    queue_rx(lo);
    for (i = 0; i < PAGE_BYTES; i++) begin
      d = 8'($urandom);
      s = s + d;
      queue_rx(d);
    end
    queue_rx(good ? ~s : ~s ^ 8'($urandom_range(1, 255)));
  endfunction

  function automatic void queue_random_packet();
    logic [7:0] v;
    logic [7:0] d;
    if ($urandom_range(0, 99) < 8) begin
      queue_rx(8'($urandom));  // line noise between packets
      return;
    end
    queue_rx(SYNC_BYTE);
    case ($urandom_range(0, 11))
      0: queue_rx(CMD_NOP);
      1: begin
        v = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
        queue_rx(CMD_SETADDR);
        queue_rx(v);
        gen_addr = v;
      end
      3: begin
        v = $urandom_range(0, 1) ? gen_cell : 8'($urandom);
        d = 8'($urandom);
        queue_rx(CMD_EEWRITE);
        queue_rx(v);
        queue_rx(d);
        if (v == gen_cell) gen_addr = d;
      end
      4: begin
        queue_rx(CMD_EEREAD);
        queue_rx(8'($urandom));
      end
      5: begin
        case ($urandom_range(0, 4))
          0, 1: v = 8'hFF;
          2: v = gen_addr;
          3: v = {4'hF, gen_addr[7:4]};
          default: v = 8'($urandom);
        endcase
        queue_rx(CMD_SET_MASK);
        queue_rx(v);
      end
      6: queue_rx(CMD_RUN_APP);
      7: queue_rx(CMD_FINISH);
      8: begin
        queue_rx(SYNC_BYTE);  // resync inside a packet
        queue_rx(CMD_SHOW);
      end
      9: begin
        v = 8'($urandom);
        // a stray program command would swallow the following packets as page data
        if (v == CMD_PROGRAM) v = CMD_NOP;
        queue_rx(v);
      end
      10: begin
        // cut short: the next packet's sync lands as the data byte
        queue_rx(CMD_EEWRITE);
        queue_rx(8'($urandom));
      end
      default: queue_rx(CMD_SHOW);
    endcase
  endfunction

  task automatic cfg_write(input logic [SBCP_PADDR_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= idx;
    pwdata  <= {24'($urandom), val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    while (n_taken != n_queued || due_requests.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_random(int count);
    int stop;
    stop = n_queued + count;
    while (n_queued < stop) queue_random_packet();
  endtask

  initial begin
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = REG_ADDR_CELL;
    pwdata        = 32'h0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cfg_write(REG_ADDR_SPARE, 8'($urandom));
    cfg_write(REG_ADDR_CELL, 8'h00);
    gen_cell = 8'h00;

    // directed: every command but program, selection cases, byte extremes
    queue_rx(8'h00);
    queue_rx(8'hFF);
    queue_cmd(CMD_NOP);
    queue_cmd(CMD_SHOW);
    queue_cmd(CMD_EEREAD);
    queue_rx(8'hFF);
    queue_cmd(CMD_EEWRITE);
    queue_rx(8'h00);
    queue_rx(8'hFF);
    queue_rx(SYNC_BYTE);
    queue_cmd(CMD_RUN_APP);
    queue_cmd(CMD_FINISH);
    queue_cmd(CMD_SETADDR);
    queue_rx(8'h23);
    queue_cmd(CMD_SET_MASK);
    queue_rx(8'hF2);
    queue_cmd(CMD_SHOW);
    queue_cmd(CMD_SET_MASK);
    queue_rx(8'h00);
    queue_cmd(CMD_SHOW);
    gen_addr = 8'h23;
    drain();

    // good page with stalls on both sides
    cfg_write(REG_ADDR_CELL, 8'hFF);
    gen_cell = 8'hFF;
    queue_cmd(CMD_SET_MASK);
    queue_rx(8'hFF);
    queue_page(8'hFF, 8'hFF, 1'b1);  // base wraps past the top of flash
    // sender holds off until every request is back
    drain();

    queue_random(24);
    drain();

    // bad page sum with no idling at all: fault words, then everything is ignored
    in_gap_pct    = 0;
    out_stall_pct = 0;
    queue_rx(8'h00);  // closes any packet left open by the random traffic
    queue_cmd(CMD_SET_MASK);
    queue_rx(8'hFF);
    queue_page(8'($urandom), 8'($urandom), 1'b0);
    queue_cmd(CMD_RUN_APP);
    queue_cmd(CMD_SHOW);
    queue_rx(8'h00);
    drain();
    in_gap_pct    = 30;
    out_stall_pct = 30;
    cfg_write(REG_ADDR_CELL, 8'h5A);
    queue_cmd(CMD_FINISH);
    queue_cmd(CMD_EEREAD);
    queue_rx(8'h5A);
    drain();
    repeat (20) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
